@@ design/ddoi_pkg.sv @@
// shared types, constants and helpers for the odometry integrator
`timescale 1ns / 1ps
package ddoi_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int POS_BITS_DEF   = 32;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_RADIUS   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INV_WHEEL_BASE = 1'd1;
   localparam logic [15:0] WHEEL_RADIUS_RST   = 16'd7864;
   localparam logic [19:0] INV_WHEEL_BASE_RST = 20'd115993;

   // shared multiplier operand widths, wide products are built in two passes
   localparam int A_W     = 34;
   localparam int B_W     = 32;
   localparam int MUL_W   = A_W + B_W;
   localparam int SPLIT_W = 21;
   // accumulated product width
   localparam int PROD_W  = 77;

   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_W     = 33;
   localparam logic [31:0] CORDIC_GAIN    = 32'h26DD3B6A;
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'h28BE60DC;

   localparam int SEQ_W = 5;
   localparam logic [SEQ_W-1:0] SEQ_LAST = 5'd20;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_SUM_R, MUL_DIFF_R, MUL_DR_W, MUL_DR_W_HI, MUL_RATE_DT, MUL_R28_K,
      MUL_R28_K_HI, MUL_LIN_C, MUL_LIN_S, MUL_TX_DT, MUL_TY_DT
   } mul_sel_type;

   typedef enum logic [3:0] {
      CAP_NONE, CAP_LIN, CAP_DR, CAP_RATE, CAP_R28, CAP_DYAW,
      CAP_TX, CAP_TY, CAP_DX, CAP_DY
   } cap_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      cap_sel_type cap_sel;
      logic        cordic_step;
      logic [3:0]  cordic_idx;
      logic        commit;
   } cmd_type;

   // atan(2^-i) in Q0.32 turns
   function automatic logic [31:0] atan_turn(input logic [3:0] idx);
      logic [31:0] v;
      case (idx)
         4'd0:    v = 32'h20000000;
         4'd1:    v = 32'h12E4051E;
         4'd2:    v = 32'h09FB385B;
         4'd3:    v = 32'h051111D4;
         4'd4:    v = 32'h028B0D43;
         4'd5:    v = 32'h0145D7E1;
         4'd6:    v = 32'h00A2F61E;
         4'd7:    v = 32'h00517C55;
         4'd8:    v = 32'h0028BE53;
         4'd9:    v = 32'h00145F2F;
         4'd10:   v = 32'h000A2F98;
         4'd11:   v = 32'h000517CC;
         4'd12:   v = 32'h00028BE6;
         4'd13:   v = 32'h000145F3;
         4'd14:   v = 32'h0000A2FA;
         default: v = 32'h0000517D;
      endcase
      return v;
   endfunction

   // add half an lsb, then floor shift
   function automatic logic signed [PROD_W:0] rnd_shift(
      input logic signed [PROD_W-1:0] p, input int unsigned s);
      logic signed [PROD_W:0] half;
      logic signed [PROD_W:0] e;
      half = {{PROD_W{1'b0}}, 1'b1} << (s - 1);
      e    = $signed({p[PROD_W-1], p}) + half;
      return e >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W:0] v);
      logic signed [PROD_W:0] mx;
      logic signed [PROD_W:0] mn;
      mx = $signed({{(PROD_W-30){1'b0}}, {31{1'b1}}});
      mn = $signed({{(PROD_W-30){1'b1}}, {31{1'b0}}});
      if (v > mx) return mx[31:0];
      if (v < mn) return mn[31:0];
      return v[31:0];
   endfunction

endpackage

@@ design/ddoi_ctrl.sv @@
// sequencing controller for the odometry integrator
`timescale 1ns / 1ps
module ddoi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output ddoi_pkg::cmd_type cmd
);
   import ddoi_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   state_type        state_ff, state_in;
   logic [SEQ_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.mul_sel     = MUL_NONE;
      cmd.cap_sel     = CAP_NONE;
      cmd.load        = req_tvalid && req_tready;
      cmd.cordic_idx  = cnt_ff[3:0];
      cmd.cordic_step = (state_ff == ST_RUN) && (cnt_ff < SEQ_W'(CORDIC_STEPS));
      cmd.commit      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
      if (state_ff == ST_RUN) begin
         case (cnt_ff)
            5'd0:  cmd.mul_sel = MUL_SUM_R;
            5'd1:  begin cmd.mul_sel = MUL_DIFF_R; cmd.cap_sel = CAP_LIN; end
            5'd2:  cmd.cap_sel = CAP_DR;
            5'd3:  cmd.mul_sel = MUL_DR_W;
            5'd4:  cmd.mul_sel = MUL_DR_W_HI;
            5'd5:  cmd.cap_sel = CAP_RATE;
            5'd6:  cmd.mul_sel = MUL_RATE_DT;
            5'd7:  cmd.cap_sel = CAP_R28;
            5'd8:  cmd.mul_sel = MUL_R28_K;
            5'd9:  cmd.mul_sel = MUL_R28_K_HI;
            5'd10: cmd.cap_sel = CAP_DYAW;
            5'd16: cmd.mul_sel = MUL_LIN_C;
            5'd17: begin cmd.mul_sel = MUL_LIN_S;  cmd.cap_sel = CAP_TX; end
            5'd18: begin cmd.mul_sel = MUL_TX_DT;  cmd.cap_sel = CAP_TY; end
            5'd19: begin cmd.mul_sel = MUL_TY_DT;  cmd.cap_sel = CAP_DX; end
            5'd20: cmd.cap_sel = CAP_DY;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (cmd.load) state_in = ST_RUN;
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SEQ_LAST) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (cmd.commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready)) else $error("commit into full slot");
   a_rise_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.commit)) else $error("result without commit");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready) else $error("accept while busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> cnt_ff <= SEQ_LAST) else $error("sequence overrun");

endmodule

@@ design/ddoi_datapath.sv @@
// shared multiplier, cordic and pose accumulators
`timescale 1ns / 1ps
module ddoi_datapath #(
   parameter int ANGLE_BITS = ddoi_pkg::ANGLE_BITS_DEF,
   parameter int POS_BITS   = ddoi_pkg::POS_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ddoi_pkg::cmd_type   cmd,
   input  logic signed [23:0]  rate_left,
   input  logic signed [23:0]  rate_right,
   input  logic [19:0]         delta_time,
   input  logic [15:0]         wheel_rad,
   input  logic [19:0]         inv_wheel_base,
   output logic signed [31:0]  pos_x,
   output logic signed [31:0]  pos_y,
   output logic [15:0]         heading,
   output logic signed [31:0]  lin_speed,
   output logic signed [31:0]  turn_rate
);
   import ddoi_pkg::*;

   localparam int SUM_W = ((POS_BITS > 36) ? POS_BITS : 36) + 1;
   localparam int OX_W  = (POS_BITS > 32) ? POS_BITS : 32;
   localparam logic signed [SUM_W-1:0] PMAX =
      $signed({{(SUM_W-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] PMIN =
      $signed({{(SUM_W-POS_BITS+1){1'b1}}, {(POS_BITS-1){1'b0}}});
   localparam logic signed [OX_W-1:0] OMAX = $signed({{(OX_W-31){1'b0}}, {31{1'b1}}});
   localparam logic signed [OX_W-1:0] OMIN = $signed({{(OX_W-31){1'b1}}, {31{1'b0}}});

   logic signed [24:0]           sum_ff, diff_ff;
   logic [19:0]                  dt_ff;
   logic signed [CORDIC_W-1:0]   cx_ff, cy_ff, cz_ff;
   logic [1:0]                   quad_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [31:0]           lin_ff, rate_ff;
   logic signed [41:0]           dr_ff;
   logic signed [44:0]           r28_ff;
   logic [ANGLE_BITS-1:0]        dyaw_ff;
   logic signed [33:0]           tx_ff, ty_ff;
   logic signed [35:0]           dx_ff, dy_ff;
   logic signed [POS_BITS-1:0]   x_acc_ff, y_acc_ff;
   logic [ANGLE_BITS-1:0]        yaw_ff;
   logic signed [31:0]           out_x_ff, out_y_ff, out_lin_ff, out_rate_ff;
   logic [15:0]                  out_head_ff;

   logic [31:0]                  turns;
   logic signed [CORDIC_W-1:0]   cos_v, sin_v, sh_x, sh_y, atan_v;
   logic signed [A_W-1:0]        op_a;
   logic signed [B_W-1:0]        op_b;
   logic signed [MUL_W-1:0]      mul_p;
   logic signed [PROD_W:0]       r8, r13, r20, r28, r30;
   logic [59:0]                  p_half;
   logic signed [SUM_W-1:0]      nx_raw, ny_raw, nx_sat, ny_sat;
   logic signed [OX_W-1:0]       nx_ext, ny_ext;
   logic [ANGLE_BITS-1:0]        yaw_nx;
   logic [31:0]                  head_w;

   // binary angle as Q0.32 turns
   assign turns  = {yaw_ff, {(32-ANGLE_BITS){1'b0}}};
   assign sh_x   = cx_ff >>> cmd.cordic_idx;
   assign sh_y   = cy_ff >>> cmd.cordic_idx;
   assign atan_v = CORDIC_W'($signed({1'b0, atan_turn(cmd.cordic_idx)}));

   always_comb begin
      case (quad_ff)
         2'd0:    begin cos_v = cx_ff;  sin_v = cy_ff;  end
         2'd1:    begin cos_v = -cy_ff; sin_v = cx_ff;  end
         2'd2:    begin cos_v = -cx_ff; sin_v = -cy_ff; end
         default: begin cos_v = cy_ff;  sin_v = -cx_ff; end
      endcase
   end

   // wide operands go in two passes: low bits unsigned first, then the signed top
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_sel)
         MUL_SUM_R:   begin op_a = A_W'(sum_ff);  op_b = B_W'($signed({1'b0, wheel_rad})); end
         MUL_DIFF_R:  begin op_a = A_W'(diff_ff); op_b = B_W'($signed({1'b0, wheel_rad})); end
         MUL_DR_W: begin
            op_a = A_W'($signed({1'b0, dr_ff[SPLIT_W-1:0]}));
            op_b = B_W'($signed({1'b0, inv_wheel_base}));
         end
         MUL_DR_W_HI: begin
            op_a = A_W'($signed(dr_ff[41:SPLIT_W]));
            op_b = B_W'($signed({1'b0, inv_wheel_base}));
         end
         MUL_RATE_DT: begin op_a = A_W'(rate_ff); op_b = B_W'($signed({1'b0, dt_ff})); end
         MUL_R28_K: begin
            op_a = A_W'($signed({1'b0, r28_ff[SPLIT_W-1:0]}));
            op_b = B_W'($signed({1'b0, INV_TWO_PI_Q32}));
         end
         MUL_R28_K_HI: begin
            op_a = A_W'($signed(r28_ff[44:SPLIT_W]));
            op_b = B_W'($signed({1'b0, INV_TWO_PI_Q32}));
         end
         MUL_LIN_C:   begin op_a = A_W'(lin_ff);  op_b = cos_v[B_W-1:0]; end
         MUL_LIN_S:   begin op_a = A_W'(lin_ff);  op_b = sin_v[B_W-1:0]; end
         MUL_TX_DT:   begin op_a = A_W'(tx_ff);   op_b = B_W'($signed({1'b0, dt_ff})); end
         MUL_TY_DT:   begin op_a = A_W'(ty_ff);   op_b = B_W'($signed({1'b0, dt_ff})); end
         default:     ;
      endcase
   end

   assign mul_p = op_a * op_b;

   always_comb begin
      r8     = rnd_shift(prod_ff, 8);
      r13    = rnd_shift(prod_ff, 13);
      r20    = rnd_shift(prod_ff, 20);
      r28    = rnd_shift(prod_ff, 28);
      r30    = rnd_shift(prod_ff, 30);
      p_half = prod_ff[59:0] + (60'd1 << (59 - ANGLE_BITS));
   end

   // pose update with saturation
   always_comb begin
      nx_raw = SUM_W'(x_acc_ff) + SUM_W'(dx_ff);
      ny_raw = SUM_W'(y_acc_ff) + SUM_W'(dy_ff);
      nx_sat = (nx_raw > PMAX) ? PMAX : ((nx_raw < PMIN) ? PMIN : nx_raw);
      ny_sat = (ny_raw > PMAX) ? PMAX : ((ny_raw < PMIN) ? PMIN : ny_raw);
      nx_ext = OX_W'($signed(nx_sat[POS_BITS-1:0]));
      ny_ext = OX_W'($signed(ny_sat[POS_BITS-1:0]));
      yaw_nx = yaw_ff + dyaw_ff;
      head_w = {yaw_nx, {(32-ANGLE_BITS){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_acc_ff <= '0;
         y_acc_ff <= '0;
         yaw_ff   <= '0;
      end else if (cmd.commit) begin
         x_acc_ff <= nx_sat[POS_BITS-1:0];
         y_acc_ff <= ny_sat[POS_BITS-1:0];
         yaw_ff   <= yaw_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sum_ff  <= 25'(rate_left) + 25'(rate_right);
         diff_ff <= 25'(rate_right) - 25'(rate_left);
         dt_ff   <= delta_time;
         cx_ff   <= CORDIC_W'($signed({1'b0, CORDIC_GAIN}));
         cy_ff   <= '0;
         cz_ff   <= CORDIC_W'($signed({1'b0, turns[29:0]}));
         quad_ff <= turns[31:30];
      end else if (cmd.cordic_step) begin
         if (!cz_ff[CORDIC_W-1]) begin
            cx_ff <= cx_ff - sh_y;
            cy_ff <= cy_ff + sh_x;
            cz_ff <= cz_ff - atan_v;
         end else begin
            cx_ff <= cx_ff + sh_y;
            cy_ff <= cy_ff - sh_x;
            cz_ff <= cz_ff + atan_v;
         end
      end
      // second pass adds the top partial product
      if (cmd.mul_sel == MUL_DR_W_HI || cmd.mul_sel == MUL_R28_K_HI)
         prod_ff <= prod_ff + (PROD_W'(mul_p) <<< SPLIT_W);
      else if (cmd.mul_sel != MUL_NONE)
         prod_ff <= PROD_W'(mul_p);
      case (cmd.cap_sel)
         CAP_LIN:  lin_ff  <= sat32(r13);
         CAP_DR:   dr_ff   <= prod_ff[41:0];
         CAP_RATE: rate_ff <= sat32(r28);
         CAP_R28:  r28_ff  <= r8[44:0];
         CAP_DYAW: dyaw_ff <= p_half[59 -: ANGLE_BITS];
         CAP_TX:   tx_ff   <= r30[33:0];
         CAP_TY:   ty_ff   <= r30[33:0];
         CAP_DX:   dx_ff   <= r20[35:0];
         CAP_DY:   dy_ff   <= r20[35:0];
         default:  ;
      endcase
      if (cmd.commit) begin
         out_x_ff    <= (nx_ext > OMAX) ? OMAX[31:0] :
                        ((nx_ext < OMIN) ? OMIN[31:0] : nx_ext[31:0]);
         out_y_ff    <= (ny_ext > OMAX) ? OMAX[31:0] :
                        ((ny_ext < OMIN) ? OMIN[31:0] : ny_ext[31:0]);
         out_head_ff <= head_w[31:16];
         out_lin_ff  <= lin_ff;
         out_rate_ff <= rate_ff;
      end
   end

   assign pos_x     = out_x_ff;
   assign pos_y     = out_y_ff;
   assign heading   = out_head_ff;
   assign lin_speed = out_lin_ff;
   assign turn_rate = out_rate_ff;

endmodule

@@ design/diff_drive_odometry_integrator_core.sv @@
// top level of the differential drive odometry integrator
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | req_tdata: rate_left, rate_right, delta_time
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: pos_x, pos_y, heading, lin_speed, turn_rate
//  csr     | in  | csr_we                | csr_addr, csr_wdata (no read-back)
//
// a result is registered at its commit, which follows the 21 sequencer steps after its accept;
// no new transaction is taken until the previous one is committed. one shared 34x32 multiplier
// sets the sequence, the two wide products take two passes each, and the 16-step cordic
// runs in parallel from the accept. the next transaction is taken the cycle after the
// result is committed, even while that result still waits on rsp_tready. a stalled
// result holds the commit of the following transaction. synchronous active-high reset
// clears the pose, the heading, the controller and loads the register defaults.
`timescale 1ns / 1ps
module diff_drive_odometry_integrator_core #(
   parameter int ANGLE_BITS = ddoi_pkg::ANGLE_BITS_DEF,
   parameter int POS_BITS   = ddoi_pkg::POS_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rate_left[23:0], rate_right[47:24], delta_time[67:48], zero fill
   input  logic [71:0]                     req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pos_x[31:0], pos_y[63:32], heading[79:64], lin_speed[111:80], turn_rate[143:112]
   output logic [143:0]                    rsp_tdata,
   input  logic                            csr_we,
   input  logic [ddoi_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [ddoi_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ddoi_pkg::*;

   cmd_type            cmd;
   logic [15:0]        wheel_rad_ff;
   logic [19:0]        inv_wheel_base_ff;
   logic signed [31:0] pos_x, pos_y, lin_speed, turn_rate;
   logic [15:0]        heading;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_rad_ff      <= WHEEL_RADIUS_RST;
         inv_wheel_base_ff <= INV_WHEEL_BASE_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_WHEEL_RADIUS:   wheel_rad_ff      <= csr_wdata[15:0];
            REG_INV_WHEEL_BASE: inv_wheel_base_ff <= csr_wdata[19:0];
            default:            ;
         endcase
      end
   end

   ddoi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ddoi_datapath #(
      .ANGLE_BITS (ANGLE_BITS),
      .POS_BITS   (POS_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .rate_left      ($signed(req_tdata[23:0])),
      .rate_right     ($signed(req_tdata[47:24])),
      .delta_time     (req_tdata[67:48]),
      .wheel_rad      (wheel_rad_ff),
      .inv_wheel_base (inv_wheel_base_ff),
      .pos_x          (pos_x),
      .pos_y          (pos_y),
      .heading        (heading),
      .lin_speed      (lin_speed),
      .turn_rate      (turn_rate)
   );

   // result packing, first field lowest
   assign rsp_tdata = {turn_rate, lin_speed, heading, pos_y, pos_x};

endmodule
